// ----- rtl/core/isoep_pkg.sv -----
// ----------------------------------------------------------------------------
// isoep_pkg
// Shared types, constants and tables for the timestamp to epoch converter.
// ----------------------------------------------------------------------------
package isoep_pkg;

    localparam int YEAR_W  = 14;
    localparam int FIELD_W = 7;
    localparam int POS_W   = 5;
    localparam int EPOCH_W = 39;
    localparam int DAYS_W  = 24;
    localparam int DOE_W   = 18;
    localparam int TOD_W   = 17;
    localparam int ERA_W   = 6;
    localparam int QUO_W   = 5;
    localparam int YOE_W   = 9;
    localparam int RECIP_W = 15;

    localparam logic [POS_W-1:0] POS_MAX = 5'd31;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;

    localparam logic [5:0] LEN_PLAIN   = 6'd16;
    localparam logic [5:0] LEN_PLAIN_Z = 6'd17;
    localparam logic [5:0] LEN_SEC     = 6'd19;
    localparam logic [5:0] LEN_SEC_Z   = 6'd20;

    localparam logic [YEAR_W-1:0] DIV_400 = 14'd400;
    // year / 400 = ((year >> 4) * 41) >> 10, exact for years up to 9999
    localparam logic [RECIP_W-1:0] DIV25_RECIP = 15'd41;
    localparam int                 DIV25_SHIFT = 10;

    localparam logic signed [DAYS_W-1:0]  ERA_DAYS    = 24'sd146097;
    localparam logic signed [DAYS_W-1:0]  EPOCH_SHIFT = 24'sd719468;
    localparam logic signed [EPOCH_W-1:0] SEC_PER_DAY = 39'sd86400;
    localparam logic [TOD_W-1:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [TOD_W-1:0] SEC_PER_MIN  = 17'd60;

    localparam logic [FIELD_W-1:0] MAX_HOUR   = 7'd23;
    localparam logic [FIELD_W-1:0] MAX_MINUTE = 7'd59;
    localparam logic [FIELD_W-1:0] MAX_SECOND = 7'd60;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
        logic               fmt_ok;
    } rec_t;

    typedef enum logic [2:0] {
        CV_IDLE,
        CV_DIV,
        CV_CHECK,
        CV_DAYS,
        CV_MUL,
        CV_SUM,
        CV_DONE
    } conv_state_t;

    // days in month; zero for a month outside 1..12
    function automatic logic [4:0] month_days(input logic [FIELD_W-1:0] m, input logic leap);
        logic [4:0] d;
        begin
            unique case (m)
                7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: d = 5'd31;
                7'd4, 7'd6, 7'd9, 7'd11:                    d = 5'd30;
                7'd2:                                       d = leap ? 5'd29 : 5'd28;
                default:                                    d = 5'd0;
            endcase
            return d;
        end
    endfunction

    // day of a March-based year on which the month starts
    function automatic logic [8:0] doy_base(input logic [FIELD_W-1:0] m);
        logic [8:0] b;
        begin
            unique case (m)
                7'd3:    b = 9'd0;
                7'd4:    b = 9'd31;
                7'd5:    b = 9'd61;
                7'd6:    b = 9'd92;
                7'd7:    b = 9'd122;
                7'd8:    b = 9'd153;
                7'd9:    b = 9'd184;
                7'd10:   b = 9'd214;
                7'd11:   b = 9'd245;
                7'd12:   b = 9'd275;
                7'd1:    b = 9'd306;
                7'd2:    b = 9'd337;
                default: b = 9'd0;
            endcase
            return b;
        end
    endfunction

endpackage

// ----- rtl/core/isoep_scan.sv -----
// ----------------------------------------------------------------------------
// isoep_scan
// Byte scanner: checks layout, accumulates decimal fields and pushes one
// record per timestamp into the queue.
// ----------------------------------------------------------------------------
module isoep_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_char_in,
    input  logic                s_is_last,
    input  logic                q_full,
    output logic                q_push,
    output isoep_pkg::rec_t     q_rec
);
    import isoep_pkg::*;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [FIELD_W-1:0] month_reg, month_next;
    logic [FIELD_W-1:0] day_reg, day_next;
    logic [FIELD_W-1:0] hour_reg, hour_next;
    logic [FIELD_W-1:0] minute_reg, minute_next;
    logic [FIELD_W-1:0] second_reg, second_next;
    logic               has_sec_reg, has_sec_next;
    logic               err_reg, err_next;

    logic               accept;
    logic               is_dig;
    logic [3:0]         dig_val;
    logic [5:0]         len;
    logic               len_ok;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign is_dig  = (s_char_in >= CH_0) && (s_char_in <= CH_9);
    assign dig_val = is_dig ? 4'(s_char_in - CH_0) : 4'd0;
    assign len     = 6'(pos_reg) + 6'd1;

    always_comb begin
        pos_next     = pos_reg;
        year_next    = year_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        has_sec_next = has_sec_reg;
        err_next     = err_reg;
        q_push       = 1'b0;
        len_ok       = 1'b0;
        q_rec        = '0;

        if (accept) begin
            unique case (pos_reg)
                5'd0, 5'd1, 5'd2, 5'd3: begin
                    err_next  = err_reg | !is_dig;
                    year_next = YEAR_W'(year_reg * 14'd10 + 14'(dig_val));
                end
                5'd5, 5'd6: begin
                    err_next   = err_reg | !is_dig;
                    month_next = FIELD_W'(month_reg * 7'd10 + 7'(dig_val));
                end
                5'd8, 5'd9: begin
                    err_next = err_reg | !is_dig;
                    day_next = FIELD_W'(day_reg * 7'd10 + 7'(dig_val));
                end
                5'd11, 5'd12: begin
                    err_next  = err_reg | !is_dig;
                    hour_next = FIELD_W'(hour_reg * 7'd10 + 7'(dig_val));
                end
                5'd14, 5'd15: begin
                    err_next    = err_reg | !is_dig;
                    minute_next = FIELD_W'(minute_reg * 7'd10 + 7'(dig_val));
                end
                5'd4, 5'd7: begin
                    err_next = err_reg | (s_char_in != CH_DASH);
                end
                5'd10: begin
                    err_next = err_reg | (s_char_in != CH_T);
                end
                5'd13: begin
                    err_next = err_reg | (s_char_in != CH_COLON);
                end
                5'd16: begin
                    if (s_char_in == CH_COLON) begin
                        has_sec_next = 1'b1;
                    end else if (s_char_in != CH_Z) begin
                        err_next = 1'b1;
                    end
                end
                5'd17, 5'd18: begin
                    err_next    = err_reg | !is_dig | !has_sec_reg;
                    second_next = FIELD_W'(second_reg * 7'd10 + 7'(dig_val));
                end
                5'd19: begin
                    err_next = err_reg | (s_char_in != CH_Z) | !has_sec_reg;
                end
                default: begin
                    err_next = 1'b1;
                end
            endcase

            if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + 5'd1;
            end

            if (s_is_last) begin
                priority if (len == LEN_PLAIN) begin
                    len_ok = 1'b1;
                end else if (len == LEN_PLAIN_Z) begin
                    len_ok = !has_sec_next;
                end else if (len == LEN_SEC || len == LEN_SEC_Z) begin
                    len_ok = has_sec_next;
                end else begin
                    len_ok = 1'b0;
                end

                q_push        = 1'b1;
                q_rec.year    = year_next;
                q_rec.month   = month_next;
                q_rec.day     = day_next;
                q_rec.hour    = hour_next;
                q_rec.minute  = minute_next;
                q_rec.second  = second_next;
                q_rec.fmt_ok  = len_ok && !err_next;

                pos_next     = '0;
                year_next    = '0;
                month_next   = '0;
                day_next     = '0;
                hour_next    = '0;
                minute_next  = '0;
                second_next  = '0;
                has_sec_next = 1'b0;
                err_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            year_reg    <= '0;
            month_reg   <= '0;
            day_reg     <= '0;
            hour_reg    <= '0;
            minute_reg  <= '0;
            second_reg  <= '0;
            has_sec_reg <= 1'b0;
            err_reg     <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            year_reg    <= year_next;
            month_reg   <= month_next;
            day_reg     <= day_next;
            hour_reg    <= hour_next;
            minute_reg  <= minute_next;
            second_reg  <= second_next;
            has_sec_reg <= has_sec_next;
            err_reg     <= err_next;
        end
    end

endmodule

// ----- rtl/core/isoep_fifo.sv -----
// ----------------------------------------------------------------------------
// isoep_fifo
// Two-entry record queue between scanner and converter.
// ----------------------------------------------------------------------------
module isoep_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  isoep_pkg::rec_t push_rec,
    input  logic            pop,
    output isoep_pkg::rec_t pop_rec,
    output logic            full,
    output logic            empty
);
    import isoep_pkg::*;

    rec_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_rec = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ----- rtl/core/isoep_conv.sv -----
// ----------------------------------------------------------------------------
// isoep_conv
// Converter: date check, days-from-civil and seconds, one record at a time.
// ----------------------------------------------------------------------------
module isoep_conv (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_empty,
    output logic                              q_pop,
    input  isoep_pkg::rec_t                   q_rec,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [isoep_pkg::EPOCH_W-1:0] m_epoch_seconds,
    output logic                              m_valid_res
);
    import isoep_pkg::*;

    conv_state_t state_reg, state_next;

    rec_t                       rec_reg;
    logic [YEAR_W-1:0]          rem_reg;
    logic [QUO_W-1:0]           quo_reg;
    logic signed [ERA_W-1:0]    era_reg;
    logic [DOE_W-1:0]           doe_reg;
    logic                       ok_reg;
    logic signed [DAYS_W-1:0]   days_reg;
    logic [TOD_W-1:0]           tod_reg;
    logic signed [EPOCH_W-1:0]  prod_reg;
    logic signed [EPOCH_W-1:0]  epoch_reg;
    logic                       res_ok_reg;

    logic [YEAR_W-5:0]          year_hi;
    logic [RECIP_W-1:0]         recip_prod;
    logic [QUO_W-1:0]           quo;
    logic [YEAR_W-1:0]          rem;
    logic [YOE_W-1:0]           rem9;
    logic                       leap;
    logic                       early;
    logic [YOE_W-1:0]           yoe;
    logic signed [ERA_W-1:0]    era;
    logic [1:0]                 c100;
    logic [DOE_W-1:0]           doe;
    logic                       date_ok;
    logic                       time_ok;
    logic signed [EPOCH_W-1:0]  days_ext;

    assign year_hi    = rec_reg.year[YEAR_W-1:4];
    assign recip_prod = RECIP_W'(year_hi) * DIV25_RECIP;
    assign quo        = recip_prod[RECIP_W-1:DIV25_SHIFT];
    assign rem        = rec_reg.year - YEAR_W'(quo) * DIV_400;
    assign rem9    = YOE_W'(rem_reg);
    assign leap    = (rem9[1:0] == 2'd0) && (rem9 != 9'd100) && (rem9 != 9'd200)
                     && (rem9 != 9'd300);
    assign early   = (rec_reg.month <= 7'd2);

    always_comb begin
        era = signed'(ERA_W'(quo_reg));
        yoe = rem9;
        if (early) begin
            if (rem9 == 9'd0) begin
                era = signed'(ERA_W'(quo_reg)) - 6'sd1;
                yoe = 9'd399;
            end else begin
                yoe = rem9 - 9'd1;
            end
        end
        c100 = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
        doe  = DOE_W'(yoe) * 18'd365 + DOE_W'(yoe >> 2) - DOE_W'(c100)
               + DOE_W'(doy_base(rec_reg.month)) + DOE_W'(rec_reg.day) - 18'd1;
    end

    assign date_ok = (rec_reg.month >= 7'd1) && (rec_reg.month <= 7'd12)
                     && (rec_reg.day >= 7'd1)
                     && (rec_reg.day <= FIELD_W'(month_days(rec_reg.month, leap)));
    assign time_ok = (rec_reg.hour <= MAX_HOUR) && (rec_reg.minute <= MAX_MINUTE)
                     && (rec_reg.second <= MAX_SECOND);
    assign days_ext = {{(EPOCH_W-DAYS_W){days_reg[DAYS_W-1]}}, days_reg};

    assign q_pop           = (state_reg == CV_IDLE) && !q_empty;
    assign m_valid         = (state_reg == CV_DONE);
    assign m_epoch_seconds = epoch_reg;
    assign m_valid_res     = res_ok_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CV_IDLE:  if (!q_empty) state_next = CV_DIV;
            CV_DIV:   state_next = CV_CHECK;
            CV_CHECK: state_next = CV_DAYS;
            CV_DAYS:  state_next = CV_MUL;
            CV_MUL:   state_next = CV_SUM;
            CV_SUM:   state_next = CV_DONE;
            CV_DONE:  if (m_ready) state_next = CV_IDLE;
            default:  state_next = CV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            CV_IDLE: begin
                rec_reg <= q_rec;
            end
            CV_DIV: begin
                quo_reg <= quo;
                rem_reg <= rem;
            end
            CV_CHECK: begin
                era_reg <= era;
                doe_reg <= doe;
                ok_reg  <= rec_reg.fmt_ok && date_ok && time_ok;
            end
            CV_DAYS: begin
                days_reg <= DAYS_W'(era_reg) * ERA_DAYS + signed'(DAYS_W'(doe_reg))
                            - EPOCH_SHIFT;
                tod_reg  <= TOD_W'(rec_reg.hour) * SEC_PER_HOUR
                            + TOD_W'(rec_reg.minute) * SEC_PER_MIN
                            + TOD_W'(rec_reg.second);
            end
            CV_MUL: begin
                prod_reg <= days_ext * SEC_PER_DAY;
            end
            CV_SUM: begin
                epoch_reg  <= ok_reg ? prod_reg + signed'(EPOCH_W'(tod_reg)) : '0;
                res_ok_reg <= ok_reg;
            end
            CV_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/core/iso8601_utc_to_epoch_unit.sv -----
// ----------------------------------------------------------------------------
// iso8601_utc_to_epoch_unit
// Streams an ISO 8601 UTC timestamp one byte per beat and returns the signed
// Unix epoch in seconds with a valid flag after the last byte.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_char_in[7:0], s_is_last
//   m_      | out       | m_valid / m_ready  | m_epoch_seconds[38:0], m_valid_res
//
// The scanner takes one byte per cycle; s_ready drops only when both queue
// entries hold finished timestamps.
// Each timestamp holds the converter for a load, a divide by 400
// through a reciprocal multiply, 4 arithmetic stages and a result beat,
// which is held until m_ready accepts it.
// Synchronous active-low reset returns scanner, queue and converter to idle.
// ----------------------------------------------------------------------------
module iso8601_utc_to_epoch_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_char_in,
    input  logic                              s_is_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [isoep_pkg::EPOCH_W-1:0] m_epoch_seconds,
    output logic                              m_valid_res
);
    import isoep_pkg::*;

    logic q_push, q_pop, q_full, q_empty;
    rec_t push_rec, pop_rec;

    isoep_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_char_in (s_char_in),
        .s_is_last (s_is_last),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_rec     (push_rec)
    );

    isoep_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .pop_rec  (pop_rec),
        .full     (q_full),
        .empty    (q_empty)
    );

    isoep_conv u_conv (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .q_rec           (pop_rec),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_epoch_seconds (m_epoch_seconds),
        .m_valid_res     (m_valid_res)
    );

endmodule

// ----- rtl/core/isoep_chk.sv -----
// ----------------------------------------------------------------------------
// isoep_chk
// Port-level checks for the timestamp to epoch converter, bound to the top.
// ----------------------------------------------------------------------------
module isoep_chk (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [7:0]                        s_char_in,
    input logic                              s_is_last,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [isoep_pkg::EPOCH_W-1:0] m_epoch_seconds,
    input logic                              m_valid_res
);
    import isoep_pkg::*;

    localparam logic signed [EPOCH_W-1:0] EPOCH_MIN = -39'sd62167219200;
    localparam logic signed [EPOCH_W-1:0] EPOCH_MAX = 39'sd253402300800;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_epoch_seconds)
                                && $stable(m_valid_res))
        else $error("result beat changed while stalled");

    // refused timestamp carries zero
    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_epoch_seconds == '0)
        else $error("refused result with nonzero epoch");

    // accepted epoch inside years 0000..9999
    a_epoch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_valid_res |-> (m_epoch_seconds >= EPOCH_MIN)
                                   && (m_epoch_seconds <= EPOCH_MAX))
        else $error("accepted epoch out of range");

    // input side never becomes blocked while no bytes arrive and no result is pending downstream
    a_in_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && $past(!m_valid) && $past(!s_valid, 1) && $past(!s_valid, 2)
        && $past(!m_valid, 2) |-> s_ready || $past(s_ready) == 1'b0)
        else $error("input stalled without pending work");

endmodule

bind iso8601_utc_to_epoch_unit isoep_chk u_isoep_chk (.*);
